### design/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants for the min-heap priority queue
// Sizes, status and function codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // heap size and element width
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // fixed port field widths
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  // slot numbers run 1..CAPACITY, memory addresses 0..CAPACITY-1
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [SLOT_W-1:0]            slot_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  // request function codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // read address selection
  typedef enum logic [2:0] {
    RD_PARENT,
    RD_LAST,
    RD_ROOT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_LAST,
    S_RM_ROOT,
    S_RM_TAKE,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DN_PICK,
    S_DN_CMP,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    place_val;
    logic    up_step;
    logic    take_last;
    logic    take_root;
    logic    take_left;
    logic    pick_right;
    logic    dn_step;
    logic    out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_valid;
    logic is_insert;
    logic full;
    logic empty;
    logic pos_root;
    logic up_move;
    logic leaf;
    logic has_right;
    logic dn_move;
    logic slot_free;
  } dp_stat_t;

endpackage

### design/mhpq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_in_if: request channel of the priority queue
// Carries the function code and the value to insert.
// ----------------------------------------------------------------------------
interface mhpq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic signed [mhpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

### design/mhpq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_out_if: result channel of the priority queue
// Carries the status, the removed minimum and the fill after the request.
// ----------------------------------------------------------------------------
interface mhpq_out_if;
  logic                                valid;
  logic                                ready;
  logic        [mhpq_pkg::STATUS_W-1:0] status;
  logic signed [mhpq_pkg::VALUE_W-1:0]  min_value;
  logic        [mhpq_pkg::FILL_W-1:0]   fill;

  modport source (output valid, output status, output min_value, output fill,
                  input ready);
  modport sink   (input valid, input status, input min_value, input fill,
                  output ready);
endinterface

### design/mhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ram: generic simple dual-port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/mhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ctrl: sequencer of the priority queue
// Walks sift-up for inserts and sift-down for removes, one memory read at a
// time, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  mhpq_pkg::dp_stat_t stat,
  output mhpq_pkg::dp_cmd_t  cmd,
  output logic               in_ready
);

  mhpq_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mhpq_pkg::S_IDLE: begin
        if (stat.in_valid) begin
          if (stat.is_insert) begin
            state_next = stat.full ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_RD;
          end else begin
            state_next = stat.empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_RM_LAST;
          end
        end
      end
      mhpq_pkg::S_UP_RD:    state_next = stat.pos_root ? mhpq_pkg::S_DONE
                                                       : mhpq_pkg::S_UP_CMP;
      mhpq_pkg::S_UP_CMP:   state_next = stat.up_move ? mhpq_pkg::S_UP_RD
                                                      : mhpq_pkg::S_DONE;
      mhpq_pkg::S_RM_LAST:  state_next = mhpq_pkg::S_RM_ROOT;
      mhpq_pkg::S_RM_ROOT:  state_next = mhpq_pkg::S_RM_TAKE;
      mhpq_pkg::S_RM_TAKE:  state_next = mhpq_pkg::S_DN_LEFT;
      mhpq_pkg::S_DN_LEFT:  state_next = stat.leaf ? mhpq_pkg::S_DONE
                                                   : mhpq_pkg::S_DN_RIGHT;
      mhpq_pkg::S_DN_RIGHT: state_next = stat.has_right ? mhpq_pkg::S_DN_PICK
                                                        : mhpq_pkg::S_DN_CMP;
      mhpq_pkg::S_DN_PICK:  state_next = mhpq_pkg::S_DN_CMP;
      mhpq_pkg::S_DN_CMP:   state_next = stat.dn_move ? mhpq_pkg::S_DN_LEFT
                                                      : mhpq_pkg::S_DONE;
      mhpq_pkg::S_DONE: begin
        if (stat.slot_free) begin
          state_next = mhpq_pkg::S_IDLE;
        end
      end
      default: state_next = mhpq_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.rd_sel = mhpq_pkg::RD_ROOT;
    in_ready = 1'b0;
    case (state)
      mhpq_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = stat.in_valid;
      end
      mhpq_pkg::S_UP_RD: begin
        if (stat.pos_root) begin
          cmd.place_val = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = mhpq_pkg::RD_PARENT;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        cmd.up_step   = stat.up_move;
        cmd.place_val = !stat.up_move;
      end
      mhpq_pkg::S_RM_LAST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = mhpq_pkg::RD_LAST;
      end
      mhpq_pkg::S_RM_ROOT: begin
        cmd.take_last = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = mhpq_pkg::RD_ROOT;
      end
      mhpq_pkg::S_RM_TAKE: begin
        cmd.take_root = 1'b1;
      end
      mhpq_pkg::S_DN_LEFT: begin
        if (stat.leaf) begin
          cmd.place_val = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = mhpq_pkg::RD_LEFT;
        end
      end
      mhpq_pkg::S_DN_RIGHT: begin
        cmd.take_left = 1'b1;
        cmd.rd_en     = stat.has_right;
        cmd.rd_sel    = mhpq_pkg::RD_RIGHT;
      end
      mhpq_pkg::S_DN_PICK: begin
        cmd.pick_right = 1'b1;
      end
      mhpq_pkg::S_DN_CMP: begin
        cmd.dn_step   = stat.dn_move;
        cmd.place_val = !stat.dn_move;
      end
      mhpq_pkg::S_DONE: begin
        cmd.out_load = stat.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### design/mhpq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_dp: datapath of the priority queue
// Heap memory, element count, slot pointers, the signed compares and the
// result register that feeds the output channel.
// ----------------------------------------------------------------------------
module mhpq_dp (
  input  logic               clk,
  input  logic               rst,
  input  mhpq_pkg::dp_cmd_t  cmd,
  output mhpq_pkg::dp_stat_t stat,
  mhpq_in_if.sink            req,
  mhpq_out_if.source         rsp
);

  localparam int DW = mhpq_pkg::DATA_WIDTH;
  localparam int SW = mhpq_pkg::SLOT_W;
  localparam int AW = mhpq_pkg::ADDR_W;
  localparam int VW = mhpq_pkg::VALUE_W;
  localparam int FW = mhpq_pkg::FILL_W;
  localparam mhpq_pkg::slot_t CAP_SLOT = SW'(mhpq_pkg::CAPACITY);

  mhpq_pkg::slot_t   count;
  mhpq_pkg::slot_t   pos;
  mhpq_pkg::slot_t   child;
  mhpq_pkg::data_t   val;
  mhpq_pkg::data_t   cval;
  mhpq_pkg::data_t   minv;
  mhpq_pkg::status_t status;

  logic              out_valid;
  logic [1:0]        out_status;
  logic [VW-1:0]     out_min;
  logic [FW-1:0]     out_fill;

  logic [SW:0]       left;
  mhpq_pkg::slot_t   parent;
  mhpq_pkg::data_t   rdata;
  logic [DW-1:0]     rd_raw;
  mhpq_pkg::addr_t   rd_addr;
  mhpq_pkg::addr_t   wr_addr;
  mhpq_pkg::data_t   wr_data;
  logic              wr_en;

  // slot arithmetic
  assign left   = {pos, 1'b0};
  assign parent = pos >> 1;
  assign rdata  = mhpq_pkg::data_t'(rd_raw);

  // status to controller
  always_comb begin
    stat.in_valid  = req.valid;
    stat.is_insert = (req.func == mhpq_pkg::FUNC_INSERT);
    stat.full      = (count == CAP_SLOT);
    stat.empty     = (count == '0);
    stat.pos_root  = (pos == SW'(1));
    stat.up_move   = (val < rdata);
    stat.leaf      = (left > {1'b0, count});
    stat.has_right = (left < {1'b0, count});
    stat.dn_move   = (cval < val);
    stat.slot_free = !out_valid || rsp.ready;
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      mhpq_pkg::RD_PARENT: rd_addr = AW'(parent - SW'(1));
      mhpq_pkg::RD_LAST:   rd_addr = AW'(count - SW'(1));
      mhpq_pkg::RD_ROOT:   rd_addr = '0;
      mhpq_pkg::RD_LEFT:   rd_addr = AW'(left - (SW + 1)'(1));
      mhpq_pkg::RD_RIGHT:  rd_addr = AW'(left);
      default:             rd_addr = '0;
    endcase
  end

  // write port: the element being placed, a parent moved down, or a child moved up
  always_comb begin
    wr_en   = cmd.place_val || cmd.up_step || cmd.dn_step;
    wr_addr = AW'(pos - SW'(1));
    if (cmd.up_step) begin
      wr_data = rdata;
    end else if (cmd.dn_step) begin
      wr_data = cval;
    end else begin
      wr_data = val;
    end
  end

  mhpq_ram #(
    .WIDTH (DW),
    .DEPTH (mhpq_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (DW'(wr_data)),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  // element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load_in && stat.is_insert && !stat.full) begin
      count <= count + SW'(1);
    end else if (cmd.take_root) begin
      count <= count - SW'(1);
    end
  end

  // request capture and sift registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      val  <= mhpq_pkg::data_t'(DW'(req.value));
      pos  <= count + SW'(1);
      minv <= '0;
      if (stat.is_insert) begin
        status <= stat.full ? mhpq_pkg::ST_FULL : mhpq_pkg::ST_OK;
      end else begin
        status <= stat.empty ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_OK;
      end
    end
    if (cmd.up_step) begin
      pos <= parent;
    end
    if (cmd.take_last) begin
      val <= rdata;
    end
    if (cmd.take_root) begin
      minv <= rdata;
      pos  <= SW'(1);
    end
    if (cmd.take_left) begin
      cval  <= rdata;
      child <= SW'(left);
    end
    // right child wins only when strictly smaller
    if (cmd.pick_right && (rdata < cval)) begin
      cval  <= rdata;
      child <= child + SW'(1);
    end
    if (cmd.dn_step) begin
      pos <= child;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= status;
      out_min    <= VW'($unsigned(minv));
      out_fill   <= FW'(count);
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.min_value = out_min;
  assign rsp.fill      = out_fill;

`ifndef SYNTH
  // fill never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_SLOT)
    else $error("element count above capacity");

  // a result is loaded only into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || rsp.ready))
    else $error("result register overwritten");

  // every heap write lands on a live slot, or on the root when the last one leaves
  a_wr_live: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (pos != '0 && (pos <= count || pos == SW'(1))))
    else $error("heap write outside live slots");

  // a right child is read only when it exists
  a_right_live: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.rd_sel == mhpq_pkg::RD_RIGHT) |-> (left < {1'b0, count}))
    else $error("read of missing right child");
`endif

endmodule

### design/min_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue: binary min-heap priority queue
// Insert and remove-minimum on signed values held in a single heap memory.
//
//   channel  dir  payload                      handshake
//   req      in   func, value                  valid / ready
//   rsp      out  status, min_value, fill      valid / ready
//
// One request at a time; each gives one result. An insert reads one parent
// per level its value climbs; a remove reads the last element and the root,
// then the left child and, where it exists, the right child per level it
// sinks; a refused request goes straight to the result. The single read port
// of the heap memory is read once per step. Synchronous reset empties the
// heap at once. A waiting result holds only the finishing step; the next
// request is taken in the cycle after the result is loaded into the output
// register.
// ----------------------------------------------------------------------------
module min_heap_priority_queue (
  input logic        clk,
  input logic        rst,
  mhpq_in_if.sink    req,
  mhpq_out_if.source rsp
);

  mhpq_pkg::dp_cmd_t  cmd;
  mhpq_pkg::dp_stat_t stat;
  logic               in_ready;

  // sequencer
  mhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // heap datapath
  mhpq_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

  assign req.ready = in_ready;

endmodule

### sim/tb_min_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_heap_priority_queue: self-checking bench for the min-heap queue
// Drives insert and remove requests through the request channel, keeps its
// own heap image to predict status, minimum and fill, and checks every
// result in order. Directed corner cases come first, then random traffic
// with idle cycles on both sides and a long result hold-off.
// ----------------------------------------------------------------------------
module tb_min_heap_priority_queue;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_PCT      = 18;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 60;

  // one expected result
  typedef struct {
    mhpq_pkg::status_t                     status;
    logic signed [mhpq_pkg::VALUE_W-1:0]   min_value;
    logic        [mhpq_pkg::FILL_W-1:0]    fill;
  } heap_result_t;

  logic clk;
  logic rst;

  mhpq_in_if  req_if ();
  mhpq_out_if rsp_if ();

  min_heap_priority_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // heap image kept by the bench
  logic signed [mhpq_pkg::DATA_WIDTH-1:0] heap_image [1:mhpq_pkg::CAPACITY];
  int                                     heap_count;

  heap_result_t pending_results [$];
  int           error_count;
  bit           no_idle;
  bit           hold_req;

  // clock
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // apply one request to the heap image and return its result
  function automatic heap_result_t heap_image_step(
      input logic f, input logic signed [mhpq_pkg::VALUE_W-1:0] v);
    heap_result_t                           res;
    int                                     pos;
    int                                     child;
    logic signed [mhpq_pkg::DATA_WIDTH-1:0] last;
    res.status    = mhpq_pkg::ST_OK;
    res.min_value = '0;
    if (f == mhpq_pkg::FUNC_INSERT) begin
      if (heap_count >= mhpq_pkg::CAPACITY) begin
        res.status = mhpq_pkg::ST_FULL;
      end else begin
        heap_count++;
        pos = heap_count;
        // climb past strictly larger parents
        while (pos > 1 && v < heap_image[pos / 2]) begin
          heap_image[pos] = heap_image[pos / 2];
          pos = pos / 2;
        end
        heap_image[pos] = v;
      end
    end else begin
      if (heap_count == 0) begin
        res.status = mhpq_pkg::ST_EMPTY;
      end else begin
        last          = heap_image[heap_count];
        res.min_value = heap_image[1];
        heap_count--;
        pos = 1;
        // sink toward the smaller child, left on a tie
        while (pos * 2 <= heap_count) begin
          child = pos * 2;
          if (child < heap_count && heap_image[child + 1] < heap_image[child])
            child++;
          if (!(heap_image[child] < last))
            break;
          heap_image[pos] = heap_image[child];
          pos = child;
        end
        heap_image[pos] = last;
      end
    end
    res.fill = heap_count[mhpq_pkg::FILL_W-1:0];
    return res;
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic send_req(input logic f,
                          input logic signed [mhpq_pkg::VALUE_W-1:0] v);
    int gap;
    gap = 0;
    if (!no_idle)
      while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= f;
    req_if.value <= v;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(heap_image_step(f, v));
  endtask

  // random value: mostly full range, some near zero for ties, some extremes
  function automatic logic signed [mhpq_pkg::VALUE_W-1:0] pick_value();
    logic signed [mhpq_pkg::VALUE_W-1:0] v;
    case ($urandom_range(9))
      6, 7:    v = $signed($urandom_range(7)) - 4;
      8:       v = $urandom_range(1) ? 32'sh7FFFFFFF - $urandom_range(3)
                                     : 32'sh80000000 + $urandom_range(3);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // remove on an empty heap right after reset
  task automatic test_remove_empty();
    send_req(mhpq_pkg::FUNC_REMOVE, 32'sd0);
  endtask

  // fill to capacity with extremes and duplicates, then one refused insert
  task automatic test_fill_to_capacity();
    logic signed [mhpq_pkg::VALUE_W-1:0] vals [mhpq_pkg::CAPACITY] = '{
      32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd5,
      32'sd3, -32'sd7, 32'sd3, 32'sd100, -32'sd100, 32'sd2, 32'sd2,
      32'sh7FFFFFFE, 32'sh80000001};
    foreach (vals[i]) send_req(mhpq_pkg::FUNC_INSERT, vals[i]);
    send_req(mhpq_pkg::FUNC_INSERT, 32'sh12345678);
  endtask

  // take a few minimums out of the full heap
  task automatic test_partial_drain();
    repeat (6) send_req(mhpq_pkg::FUNC_REMOVE, $urandom);
  endtask

  // random insert/remove mix with a given insert share
  task automatic test_random_traffic(input int count, input int insert_pct);
    repeat (count) begin
      if ($urandom_range(99) < insert_pct)
        send_req(mhpq_pkg::FUNC_INSERT, pick_value());
      else
        send_req(mhpq_pkg::FUNC_REMOVE, $urandom);
    end
  endtask

  // back-to-back traffic with both sides always willing
  task automatic test_no_idle(input int count);
    no_idle = 1'b1;
    test_random_traffic(count, 55);
    no_idle = 1'b0;
  endtask

  // result side holds off long while requests keep coming
  task automatic test_result_hold_off();
    hold_req = 1'b1;
    test_random_traffic(40, 60);
  endtask

  // result side ready, random stalls, one long hold-off on request
  initial begin
    int hold_left;
    rsp_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (no_idle) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  initial begin
    heap_result_t exp_res;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, actual status %0d min %0d fill %0d",
                   $time, rsp_if.status, rsp_if.min_value, rsp_if.fill);
        end else begin
          exp_res = pending_results.pop_front();
          if (rsp_if.status !== exp_res.status) begin
            error_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_res.status, rsp_if.status);
          end
          if (rsp_if.min_value !== exp_res.min_value) begin
            error_count++;
            $display("%0t: min_value mismatch: expected %0d, actual %0d",
                     $time, exp_res.min_value, rsp_if.min_value);
          end
          if (rsp_if.fill !== exp_res.fill) begin
            error_count++;
            $display("%0t: fill mismatch: expected %0d, actual %0d",
                     $time, exp_res.fill, rsp_if.fill);
          end
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    heap_count   = 0;
    error_count  = 0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.func  <= mhpq_pkg::FUNC_INSERT;
    req_if.value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_remove_empty();
    test_fill_to_capacity();
    test_partial_drain();
    test_random_traffic(300, 65);
    test_random_traffic(300, 35);
    test_random_traffic(400, 50);
    test_no_idle(200);
    test_result_hold_off();
    test_random_traffic(200, 50);

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
